FILE: rtl/rgb555_pixel_alu_top_defines.svh
// Assertion macros for the RGB555 pixel ALU.
// Used by rgb555_pixel_alu_top.sv; no other dependencies.
`ifndef RGB555_PIXEL_ALU_TOP_DEFINES_SVH
`define RGB555_PIXEL_ALU_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb555 pixel alu assertion failed");
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb555 pixel alu assertion failed");
`else
`define RPA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/rpa_pkg.sv
// Shared types and constants for the RGB555 pixel ALU.
// No dependencies; used by rpa_channel.sv and rgb555_pixel_alu_top.sv.
package rpa_pkg;

   localparam int CH_W      = 5;
   localparam int COLOR_W   = 15;
   localparam int WORD_W    = 16;
   localparam int CMD_W     = 3;
   localparam int AMOUNT_W  = 9;

   // Channel positions in an RGB555 colour.
   localparam int SHIFT_R   = 10;
   localparam int SHIFT_G   = 5;
   localparam int SHIFT_B   = 0;

   // Channel positions used when converting a 5-6-5 word.
   localparam int SHIFT_R565 = 11;
   localparam int SHIFT_G565 = 6;

   localparam logic [AMOUNT_W-1:0] FULL_FACTOR = 9'd256;

   typedef enum logic [CMD_W-1:0] {
      CMD_MIN    = 3'd0,
      CMD_SUB    = 3'd1,
      CMD_AVG    = 3'd2,
      CMD_BLEND  = 3'd3,
      CMD_CVT565 = 3'd4,
      CMD_CVT555 = 3'd5
   } cmd_type;

endpackage

FILE: rtl/rpa_channel.sv
// One 5-bit colour channel of the pixel ALU: min, saturating subtract,
// average and blend. Depends on rpa_pkg.
module rpa_channel (
   input  rpa_pkg::cmd_type                 op,
   input  logic [rpa_pkg::CH_W-1:0]         chan_a,
   input  logic [rpa_pkg::CH_W-1:0]         chan_b,
   input  logic [rpa_pkg::AMOUNT_W-1:0]     amount,
   input  logic [rpa_pkg::AMOUNT_W-1:0]     factor,
   output logic [rpa_pkg::CH_W-1:0]         chan_out
);

   logic [rpa_pkg::AMOUNT_W-1:0] a_wide;
   logic [rpa_pkg::AMOUNT_W-1:0] sub_diff;
   logic [rpa_pkg::CH_W:0]       avg_sum;
   logic signed [rpa_pkg::CH_W:0] diff;
   logic signed [15:0]           prod;
   logic signed [15:0]           step;
   logic signed [15:0]           blend_sum;

   assign a_wide   = {{(rpa_pkg::AMOUNT_W-rpa_pkg::CH_W){1'b0}}, chan_a};
   assign sub_diff = a_wide - amount;
   assign avg_sum  = {1'b0, chan_a} + {1'b0, chan_b};

   // Signed difference times the factor; the arithmetic shift floors the
   // scaled step for negative differences as well.
   assign diff      = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
   assign prod      = $signed({7'b0, factor}) * $signed({{10{diff[rpa_pkg::CH_W]}}, diff});
   assign step      = prod >>> 8;
   assign blend_sum = $signed({11'b0, chan_a}) + step;

   always_comb begin
      case (op)
         rpa_pkg::CMD_MIN:   chan_out = (chan_a < chan_b) ? chan_a : chan_b;
         rpa_pkg::CMD_SUB:   chan_out = (a_wide > amount) ? sub_diff[rpa_pkg::CH_W-1:0] : '0;
         rpa_pkg::CMD_AVG:   chan_out = avg_sum[rpa_pkg::CH_W:1];
         rpa_pkg::CMD_BLEND: chan_out = blend_sum[rpa_pkg::CH_W-1:0];
         default:            chan_out = '0;
      endcase
   end

endmodule

FILE: rtl/rgb555_pixel_alu_top.sv
// Top level of the RGB555 pixel ALU: input register, three channel units,
// format conversions and the result register.
// Depends on rpa_pkg, rpa_channel and rgb555_pixel_alu_top_defines.svh.
//
// Usage:
//   A command is transferred at a rising clock edge where start is high and
//   busy is low. busy is high only while reset is asserted, so a new command
//   may be issued on every clock cycle.
//   req_cmd selects min, saturating subtract, average, blend, 5-6-5 convert
//   or 555 convert; unused codes give a black result.
//   Each command yields one result on rsp_color_out, marked by rsp_strobe for
//   exactly one cycle. The command passes through the input register and
//   then the result register; all arithmetic, including the 9 x 6 bit blend
//   multiply per channel, sits between them.
//   Throughput is one command per cycle, set by the single-pass datapath.
//   There is no flow control on the result side: the receiver must take
//   every strobed result.
//   Reset is synchronous and active high; it drops any command in flight.
`include "rgb555_pixel_alu_top_defines.svh"

module rgb555_pixel_alu_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rpa_pkg::CMD_W-1:0]          req_cmd,
   input  logic [rpa_pkg::WORD_W-1:0]         req_color_a,
   input  logic [rpa_pkg::COLOR_W-1:0]        req_color_b,
   input  logic [rpa_pkg::AMOUNT_W-1:0]       req_amount,
   output logic                               rsp_strobe,
   output logic [rpa_pkg::COLOR_W-1:0]        rsp_color_out
);

   localparam int CH_W = rpa_pkg::CH_W;

   logic                               s1_valid_ff;
   logic [rpa_pkg::CMD_W-1:0]          s1_cmd_ff;
   logic [rpa_pkg::WORD_W-1:0]         s1_a_ff;
   logic [rpa_pkg::COLOR_W-1:0]        s1_b_ff;
   logic [rpa_pkg::AMOUNT_W-1:0]       s1_amount_ff;

   logic                               rsp_strobe_ff;
   logic [rpa_pkg::COLOR_W-1:0]        rsp_color_ff;
   logic [rpa_pkg::COLOR_W-1:0]        rsp_color_in;

   logic                               accept;
   rpa_pkg::cmd_type                   op;
   logic [rpa_pkg::AMOUNT_W-1:0]       factor;
   logic [CH_W-1:0]                    r_out, g_out, b_out;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_a_ff      <= req_color_a;
         s1_b_ff      <= req_color_b;
         s1_amount_ff <= req_amount;
      end
      rsp_color_ff <= rsp_color_in;
   end

   assign op     = rpa_pkg::cmd_type'(s1_cmd_ff);
   // Factors above 1.0 saturate to 1.0.
   assign factor = (s1_amount_ff > rpa_pkg::FULL_FACTOR) ? rpa_pkg::FULL_FACTOR : s1_amount_ff;

   rpa_channel u_red (
      .op       (op),
      .chan_a   (s1_a_ff[rpa_pkg::SHIFT_R +: CH_W]),
      .chan_b   (s1_b_ff[rpa_pkg::SHIFT_R +: CH_W]),
      .amount   (s1_amount_ff),
      .factor   (factor),
      .chan_out (r_out)
   );

   rpa_channel u_green (
      .op       (op),
      .chan_a   (s1_a_ff[rpa_pkg::SHIFT_G +: CH_W]),
      .chan_b   (s1_b_ff[rpa_pkg::SHIFT_G +: CH_W]),
      .amount   (s1_amount_ff),
      .factor   (factor),
      .chan_out (g_out)
   );

   rpa_channel u_blue (
      .op       (op),
      .chan_a   (s1_a_ff[rpa_pkg::SHIFT_B +: CH_W]),
      .chan_b   (s1_b_ff[rpa_pkg::SHIFT_B +: CH_W]),
      .amount   (s1_amount_ff),
      .factor   (factor),
      .chan_out (b_out)
   );

   always_comb begin
      case (op)
         rpa_pkg::CMD_MIN,
         rpa_pkg::CMD_SUB,
         rpa_pkg::CMD_AVG,
         rpa_pkg::CMD_BLEND:  rsp_color_in = {r_out, g_out, b_out};
         // The 5-6-5 word drops the lowest green bit.
         rpa_pkg::CMD_CVT565: rsp_color_in = {s1_a_ff[rpa_pkg::SHIFT_R565 +: CH_W],
                                              s1_a_ff[rpa_pkg::SHIFT_G565 +: CH_W],
                                              s1_a_ff[rpa_pkg::SHIFT_B +: CH_W]};
         rpa_pkg::CMD_CVT555: rsp_color_in = s1_a_ff[rpa_pkg::COLOR_W-1:0];
         default:             rsp_color_in = '0;
      endcase
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_color_out = rsp_color_ff;

   `RPA_ASSERT_NEXT(a_accept_loads_stage, clock, reset, accept, s1_valid_ff)
   `RPA_ASSERT_IMPL(a_accept_gives_result, clock, reset, accept, ##2 rsp_strobe)
   `RPA_ASSERT_IMPL(a_no_spurious_result, clock, reset, !accept, ##2 !rsp_strobe)
   `RPA_ASSERT_IMPL(a_unused_cmd_black, clock, reset, accept && (req_cmd > rpa_pkg::CMD_CVT555), ##2 (rsp_color_out == '0))

endmodule
